### rtl/jmp_pkg.sv
// Package for the joystick message parser: item structs, result kinds,
// report groups, config register indexes and report defaults. No dependencies.
package jmp_pkg;

    // Result kinds
    localparam logic [1:0] KIND_READ      = 2'd0;
    localparam logic [1:0] KIND_DONE      = 2'd1;
    localparam logic [1:0] KIND_MALFORMED = 2'd2;
    localparam logic [1:0] KIND_TRUNC     = 2'd3;

    // Report groups for reads
    localparam logic [1:0] GRP_AXES    = 2'd0;
    localparam logic [1:0] GRP_BUTTONS = 2'd1;
    localparam logic [1:0] GRP_HATS    = 2'd2;

    // Function codes
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Config register indexes
    localparam logic [1:0] CFG_TAG_AXIS   = 2'd0;
    localparam logic [1:0] CFG_TAG_BUTTON = 2'd1;
    localparam logic [1:0] CFG_TAG_HAT    = 2'd2;

    localparam logic [7:0] TAG_AXIS_RST   = 8'd1;
    localparam logic [7:0] TAG_BUTTON_RST = 8'd2;
    localparam logic [7:0] TAG_HAT_RST    = 8'd3;

    // Default report
    localparam logic [15:0] AXIS_CENTER = 16'h8000;
    localparam logic [15:0] AXIS_IDLE   = 16'hFFFF;
    localparam logic [15:0] BUTTON_IDLE = 16'h0000;
    localparam logic [7:0]  HAT_IDLE    = 8'hFF;
    localparam int          NUM_CENTER_AXES = 2;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
        logic       last_byte;
        logic [1:0] read_group;
        logic [2:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
        logic [15:0] bytes_used;
    } t_out_item;

    // Report update from the parser to the report store
    typedef struct packed {
        logic        restore;
        logic        axis_we;
        logic        button_we;
        logic        hat_we;
        logic [2:0]  idx;
        logic [15:0] value;
    } t_rpt_wr;

    // Index of the lowest set bit (0 when none)
    function automatic logic [2:0] lowest_bit(input logic [7:0] m);
        logic [2:0] b;
        b = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (m[i]) b = 3'(i);
        end
        return b;
    endfunction

endpackage

### rtl/joystick_message_parser_unit.sv
// Top level of the joystick message parser: input register, parser, report
// store and result register. Uses jmp_pkg, jmp_parse, jmp_report.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------
//  in      | input     | i_in_valid / o_in_stall | i_in_item  (t_in_item)
//  out     | output    | o_out_valid/ i_out_stall| o_out_item (t_out_item)
//  cfg     | input     | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// One item per cycle sustained unless a stalled output holds back an item;
// the result register loads as an item advances out of the input register,
// raising o_out_valid. An item sits in the input register, is parsed or read
// there, and its result (if any) lands in the result register.
// Synchronous active-low reset restores tags, parse state and default report.
// A stalled output only holds back items that produce a result.
module joystick_message_parser_unit #(
    parameter int NUM_AXES         = 8,
    parameter int NUM_BUTTON_WORDS = 8,
    parameter int NUM_HATS         = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  jmp_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output jmp_pkg::t_out_item o_out_item
);
    logic               r_in_valid;
    jmp_pkg::t_in_item  r_in_item;
    logic               r_out_valid;
    jmp_pkg::t_out_item r_out_item;

    logic               has_result;
    logic               advance;
    logic               push;
    jmp_pkg::t_rpt_wr   wr;
    logic [1:0]         end_kind;
    logic [15:0]        push_count;
    logic [15:0]        count;
    logic [15:0]        rd_value;

    assign has_result = (r_in_item.func == jmp_pkg::FUNC_READ) || r_in_item.last_byte;
    assign advance    = r_in_valid && (!has_result || !r_out_valid || !i_out_stall);
    assign push       = advance && (r_in_item.func == jmp_pkg::FUNC_PUSH);
    assign o_in_stall = r_in_valid && !advance;

    jmp_parse #(
        .NUM_AXES        (NUM_AXES),
        .NUM_BUTTON_WORDS(NUM_BUTTON_WORDS),
        .NUM_HATS        (NUM_HATS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_data      (r_in_item.data_byte),
        .i_last      (r_in_item.last_byte),
        .o_wr        (wr),
        .o_end_kind  (end_kind),
        .o_push_count(push_count),
        .o_count     (count)
    );

    jmp_report #(
        .NUM_AXES        (NUM_AXES),
        .NUM_BUTTON_WORDS(NUM_BUTTON_WORDS),
        .NUM_HATS        (NUM_HATS)
    ) u_report (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_rd_group(r_in_item.read_group),
        .i_rd_index(r_in_item.read_index),
        .o_rd_value(rd_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid <= (i_in_valid && !o_in_stall) || (r_in_valid && !advance);
            if (advance && has_result) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
        if (advance && has_result) begin
            if (r_in_item.func == jmp_pkg::FUNC_READ) begin
                r_out_item.kind       <= jmp_pkg::KIND_READ;
                r_out_item.value      <= rd_value;
                r_out_item.bytes_used <= count;
            end else begin
                r_out_item.kind       <= end_kind;
                r_out_item.value      <= 16'd0;
                r_out_item.bytes_used <= push_count;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stall without a held item");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && has_result |=> r_out_valid)
        else $error("result of an item was not registered");

    a_end_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_item.kind != jmp_pkg::KIND_READ) |-> r_out_item.value == 16'd0)
        else $error("end-of-message result carries a value");

    a_no_write_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !push |-> !(wr.restore || wr.axis_we || wr.button_we || wr.hat_we))
        else $error("report written without a pushed byte");

endmodule

### rtl/jmp_report.sv
// Report store of the joystick message parser: axes, button words, hats.
// Takes updates as jmp_pkg::t_rpt_wr; read port is combinational. Uses jmp_pkg.
module jmp_report #(
    parameter int NUM_AXES         = 8,
    parameter int NUM_BUTTON_WORDS = 8,
    parameter int NUM_HATS         = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  jmp_pkg::t_rpt_wr i_wr,
    input  logic [1:0]       i_rd_group,
    input  logic [2:0]       i_rd_index,
    output logic [15:0]      o_rd_value
);
    localparam int AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam int BTW = (NUM_BUTTON_WORDS > 1) ? $clog2(NUM_BUTTON_WORDS) : 1;
    localparam int HTW = (NUM_HATS > 1) ? $clog2(NUM_HATS) : 1;

    logic [15:0] r_axis [NUM_AXES];
    logic [15:0] r_button [NUM_BUTTON_WORDS];
    logic [7:0]  r_hat [NUM_HATS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_wr.restore) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_axis[i] <= (i < jmp_pkg::NUM_CENTER_AXES) ? jmp_pkg::AXIS_CENTER
                                                            : jmp_pkg::AXIS_IDLE;
            end
            for (int i = 0; i < NUM_BUTTON_WORDS; i++) begin
                r_button[i] <= jmp_pkg::BUTTON_IDLE;
            end
            for (int i = 0; i < NUM_HATS; i++) begin
                r_hat[i] <= jmp_pkg::HAT_IDLE;
            end
        end else begin
            if (i_wr.axis_we) begin
                r_axis[i_wr.idx[AXW-1:0]] <= i_wr.value;
            end
            if (i_wr.button_we) begin
                r_button[i_wr.idx[BTW-1:0]] <= i_wr.value;
            end
            if (i_wr.hat_we) begin
                r_hat[i_wr.idx[HTW-1:0]] <= i_wr.value[7:0];
            end
        end
    end

    always_comb begin
        o_rd_value = 16'd0;
        case (i_rd_group)
            jmp_pkg::GRP_AXES: begin
                if ({1'b0, i_rd_index} < 4'(NUM_AXES)) begin
                    o_rd_value = r_axis[i_rd_index[AXW-1:0]];
                end
            end
            jmp_pkg::GRP_BUTTONS: begin
                if ({1'b0, i_rd_index} < 4'(NUM_BUTTON_WORDS)) begin
                    o_rd_value = r_button[i_rd_index[BTW-1:0]];
                end
            end
            jmp_pkg::GRP_HATS: begin
                if ({1'b0, i_rd_index} < 4'(NUM_HATS)) begin
                    o_rd_value = {8'd0, r_hat[i_rd_index[HTW-1:0]]};
                end
            end
            default: o_rd_value = 16'd0;
        endcase
    end

endmodule

### rtl/jmp_parse.sv
// Section parser of the joystick message parser: tag registers, parse state,
// byte counter; emits report updates and end-of-message kinds. Uses jmp_pkg.
module jmp_parse #(
    parameter int NUM_AXES         = 8,
    parameter int NUM_BUTTON_WORDS = 8,
    parameter int NUM_HATS         = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_push,
    input  logic [7:0]       i_data,
    input  logic             i_last,
    output jmp_pkg::t_rpt_wr o_wr,
    output logic [1:0]       o_end_kind,
    output logic [15:0]      o_push_count,
    output logic [15:0]      o_count
);
    typedef enum logic [1:0] {PH_TAG, PH_MAP, PH_LOW, PH_HIGH} t_phase;
    typedef enum logic [1:0] {SEC_AXIS, SEC_BUTTON, SEC_HAT} t_sec;

    localparam logic [7:0] MASK_AX = (NUM_AXES >= 8) ? 8'hFF : 8'((1 << NUM_AXES) - 1);
    localparam logic [7:0] MASK_BT =
        (NUM_BUTTON_WORDS >= 8) ? 8'hFF : 8'((1 << NUM_BUTTON_WORDS) - 1);
    localparam logic [7:0] MASK_HT = (NUM_HATS >= 8) ? 8'hFF : 8'((1 << NUM_HATS) - 1);

    logic [7:0]  r_tag_axis, r_tag_button, r_tag_hat;
    t_phase      r_phase, n_phase;
    t_sec        r_sec, n_sec;
    logic [7:0]  r_map, n_map;
    logic [7:0]  r_low, n_low;
    logic [15:0] r_count, n_count;
    logic        r_skip, n_skip;

    logic [15:0] count_inc;
    logic [2:0]  lb;
    logic [7:0]  sec_mask;
    logic [7:0]  map_rest;

    assign count_inc = (r_count == jmp_pkg::COUNT_MAX) ? r_count : r_count + 16'd1;
    assign lb        = jmp_pkg::lowest_bit(r_map);
    assign map_rest  = r_map & (r_map - 8'd1);

    always_comb begin
        case (r_sec)
            SEC_AXIS:   sec_mask = MASK_AX;
            SEC_BUTTON: sec_mask = MASK_BT;
            default:    sec_mask = MASK_HT;
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_sec      = r_sec;
        n_map      = r_map;
        n_low      = r_low;
        n_count    = r_count;
        n_skip     = r_skip;
        o_wr       = '0;
        o_wr.idx   = lb;
        o_end_kind = jmp_pkg::KIND_DONE;
        if (i_push) begin
            n_count = count_inc;
            if (!r_skip) begin
                case (r_phase)
                    PH_TAG: begin
                        // axis wins over button, button over hat
                        if (i_data == r_tag_axis) begin
                            n_sec   = SEC_AXIS;
                            n_phase = PH_MAP;
                        end else if (i_data == r_tag_button) begin
                            n_sec   = SEC_BUTTON;
                            n_phase = PH_MAP;
                        end else if (i_data == r_tag_hat) begin
                            n_sec   = SEC_HAT;
                            n_phase = PH_MAP;
                        end else begin
                            o_wr.restore = 1'b1;
                            n_skip       = 1'b1;
                        end
                    end
                    PH_MAP: begin
                        n_map   = i_data & sec_mask;
                        n_phase = ((i_data & sec_mask) != 8'd0) ? PH_LOW : PH_TAG;
                    end
                    PH_LOW: begin
                        if (r_sec == SEC_HAT) begin
                            o_wr.hat_we = ({1'b0, lb} < 4'(NUM_HATS));
                            o_wr.value  = {8'd0, i_data};
                            n_map       = map_rest;
                            n_phase     = (map_rest != 8'd0) ? PH_LOW : PH_TAG;
                        end else begin
                            n_low   = i_data;
                            n_phase = PH_HIGH;
                        end
                    end
                    default: begin
                        o_wr.value = {i_data, r_low};
                        if (r_sec == SEC_AXIS) begin
                            o_wr.axis_we = ({1'b0, lb} < 4'(NUM_AXES));
                        end else begin
                            o_wr.button_we = ({1'b0, lb} < 4'(NUM_BUTTON_WORDS));
                        end
                        n_map   = map_rest;
                        n_phase = (map_rest != 8'd0) ? PH_LOW : PH_TAG;
                    end
                endcase
            end
            if (n_skip) begin
                o_end_kind = jmp_pkg::KIND_MALFORMED;
            end else if (n_phase != PH_TAG) begin
                o_end_kind = jmp_pkg::KIND_TRUNC;
            end
            if (i_last) begin
                n_phase = PH_TAG;
                n_sec   = SEC_AXIS;
                n_map   = 8'd0;
                n_low   = 8'd0;
                n_count = 16'd0;
                n_skip  = 1'b0;
            end
        end
    end

    assign o_push_count = count_inc;
    assign o_count      = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_axis   <= jmp_pkg::TAG_AXIS_RST;
            r_tag_button <= jmp_pkg::TAG_BUTTON_RST;
            r_tag_hat    <= jmp_pkg::TAG_HAT_RST;
            r_phase      <= PH_TAG;
            r_sec        <= SEC_AXIS;
            r_map        <= 8'd0;
            r_low        <= 8'd0;
            r_count      <= 16'd0;
            r_skip       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    jmp_pkg::CFG_TAG_AXIS:   r_tag_axis   <= i_cfg_data;
                    jmp_pkg::CFG_TAG_BUTTON: r_tag_button <= i_cfg_data;
                    jmp_pkg::CFG_TAG_HAT:    r_tag_hat    <= i_cfg_data;
                    default: ;
                endcase
            end
            r_phase <= n_phase;
            r_sec   <= n_sec;
            r_map   <= n_map;
            r_low   <= n_low;
            r_count <= n_count;
            r_skip  <= n_skip;
        end
    end

endmodule
